/* src/swffe_pkg.sv */
// Shared types and constants for the sync-word frame field extractor.
// No dependencies; used by the capture unit, the top level and the testbench.
`timescale 1ns / 1ps

package swffe_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned HIST_W    = 24;

  // Header length and the shortest frame that still fills all four words
  localparam logic [7:0] HDR_BYTES = 8'd4;
  localparam logic [7:0] MIN_FRAME = 8'd20;
  localparam logic [7:0] MAX_OFF   = 8'd255;
  localparam logic [1:0] HIST_FULL = 2'd3;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SYNC_PATTERN = 1'b0,
    REG_FRAME_LENGTH = 1'b1
  } cfg_reg_t;

  // Control handed to the word capture unit
  typedef struct packed {
    logic       wr_en;
    logic [7:0] offset;
  } cap_ctl_t;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

endpackage

/* src/swffe_word_capture.sv */
// Word capture unit: assembles frame bytes 4..19 into four little-endian words.
// Depends on swffe_pkg.
`timescale 1ns / 1ps

module swffe_word_capture (
  input  logic                clk,
  input  logic                rst_n,
  input  swffe_pkg::cap_ctl_t ctl,
  input  logic [7:0]          rx_byte,
  output swffe_pkg::words_t   words_nxt
);

  swffe_pkg::words_t words_r;
  logic [7:0]        rel_off;
  logic [1:0]        word_sel;
  logic [1:0]        byte_sel;

  assign rel_off  = ctl.offset - swffe_pkg::HDR_BYTES;
  assign word_sel = rel_off[3:2];
  assign byte_sel = ctl.offset[1:0];

  // Merged view: the byte being written this cycle is already in place
  always_comb begin
    words_nxt = words_r;
    if (ctl.wr_en) begin
      words_nxt[word_sel][byte_sel*8 +: 8] = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
    end else begin
      words_r <= words_nxt;
    end
  end

endmodule

/* src/sync_word_frame_field_extractor.sv */
// Top level of the sync-word frame field extractor.
// Depends on swffe_pkg and swffe_word_capture.
`timescale 1ns / 1ps

// Received bytes arrive one per in_ transfer. While hunting, the block holds
// the last three bytes and compares them, with the new byte, against the
// sync pattern (first received byte in bits 31..24); a match needs three real
// history bytes, so cleared history after reset or after a frame never counts.
// After a match the frame is collected: bytes 4..19 form four little-endian
// words, further bytes up to frame_length (values below 20 act as 20) are
// skipped, and the last byte yields one record on out_, in the next cycle. A
// frame_length written mid-frame below the current offset ends the frame at
// offset 255. Sync bytes inside a frame are payload. Rate: one byte per cycle;
// the single output register is the only limit, so in_tready drops only when
// the frame's last byte is due while an earlier record still waits.
module sync_word_frame_field_extractor (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] frame_counter, [63:32] rate_x,
                                   // [95:64] rate_y, [127:96] rate_z
  // configuration
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  // configuration registers
  logic [31:0] sync_pattern_r;
  logic [7:0]  frame_length_r;

  // hunt and frame state
  logic [23:0] recent_r, recent_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  offset_r, offset_nxt;

  // output register
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  logic                in_xfer;
  logic                at_end;
  logic                emit;
  logic [7:0]          last_off;
  logic [31:0]         window;
  logic                sync_hit;
  swffe_pkg::cap_ctl_t cap_ctl;
  swffe_pkg::words_t   words_nxt;

  // last byte offset of the frame, short lengths clamped to the minimum
  assign last_off = ((frame_length_r < swffe_pkg::MIN_FRAME) ?
                     swffe_pkg::MIN_FRAME : frame_length_r) - 8'd1;

  // end of frame depends only on state, never on the incoming byte
  assign at_end   = in_frame_r && (offset_r == last_off || offset_r == swffe_pkg::MAX_OFF);
  assign in_tready = !at_end || !out_valid_r || out_tready;
  assign in_xfer  = in_tvalid && in_tready;
  assign emit     = in_xfer && at_end;

  assign window   = {recent_r, in_tdata};
  assign sync_hit = (offset_r >= {6'd0, swffe_pkg::HIST_FULL}) && (window == sync_pattern_r);

  // write a payload byte while collecting offsets 4..19
  assign cap_ctl.wr_en  = in_xfer && in_frame_r &&
                          offset_r >= swffe_pkg::HDR_BYTES && offset_r < swffe_pkg::MIN_FRAME;
  assign cap_ctl.offset = offset_r;

  swffe_word_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cap_ctl),
    .rx_byte   (in_tdata),
    .words_nxt (words_nxt)
  );

  always_comb begin
    recent_nxt   = recent_r;
    in_frame_nxt = in_frame_r;
    offset_nxt   = offset_r;
    if (in_xfer) begin
      if (!in_frame_r) begin
        if (sync_hit) begin
          // header found: drop history, continue after the four header bytes
          in_frame_nxt = 1'b1;
          offset_nxt   = swffe_pkg::HDR_BYTES;
          recent_nxt   = '0;
        end else begin
          recent_nxt = window[23:0];
          if (offset_r < {6'd0, swffe_pkg::HIST_FULL}) begin
            offset_nxt = offset_r + 8'd1;
          end
        end
      end else if (at_end) begin
        // frame done: back to hunting with cleared history
        in_frame_nxt = 1'b0;
        offset_nxt   = '0;
        recent_nxt   = '0;
      end else begin
        offset_nxt = offset_r + 8'd1;
      end
    end
  end

  // hold a record until its transfer, load a new one on the frame's last byte
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = words_nxt;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r <= '0;
      frame_length_r <= swffe_pkg::MIN_FRAME;
      recent_r       <= '0;
      in_frame_r     <= 1'b0;
      offset_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (swffe_pkg::cfg_reg_t'(cfg_addr))
          swffe_pkg::REG_SYNC_PATTERN: sync_pattern_r <= cfg_wdata;
          swffe_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      recent_r    <= recent_nxt;
      in_frame_r  <= in_frame_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* src/swffe_checker.sv */
// Port-level checker for the sync-word frame field extractor, with its bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module swffe_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // a waiting record holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("record changed or vanished while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("record present after reset");

  // a record appears only as the result of an input transfer
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("record without an input transfer");

  // input back-pressure only while a record is stuck
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with a free output register");

endmodule

bind sync_word_frame_field_extractor swffe_checker u_swffe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb_sync_word_frame_field_extractor.sv */
// Self-checking testbench for the sync-word frame field extractor.
// Needs swffe_pkg and the block; predicts each gyro record from the accepted bytes.
`timescale 1ns / 1ps

module tb_sync_word_frame_field_extractor;
  import swffe_pkg::*;

  // Same layout as out_tdata: frame_counter in the lowest 32 bits
  typedef struct packed {
    logic [WORD_W-1:0] rate_z;
    logic [WORD_W-1:0] rate_y;
    logic [WORD_W-1:0] rate_x;
    logic [WORD_W-1:0] frame_counter;
  } gyro_record_t;

  localparam int unsigned PHASE_BYTES   = 72;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;   // [7:0] rx_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;         // [31:0] frame_counter, [63:32] rate_x,
                                   // [95:64] rate_y, [127:96] rate_z
  logic         cfg_we     = 1'b0;
  logic [0:0]   cfg_addr   = REG_SYNC_PATTERN;
  logic [31:0]  cfg_wdata  = '0;

  sync_word_frame_field_extractor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Deframer shadow state and register copies, reset values from the start
  logic [31:0]       sync_word  = '0;
  logic [7:0]        frame_len  = MIN_FRAME;
  logic [HIST_W-1:0] hunt_hist  = '0;
  logic              collecting = 1'b0;
  logic [7:0]        frame_pos  = '0;
  logic [WORD_W-1:0] word_buf [NUM_WORDS] = '{default: '0};
  gyro_record_t      pending_records [$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned bytes_moved        = 0;
  int unsigned records_checked    = 0;
  int unsigned reg_writes         = 0;
  int unsigned error_count        = 0;

  // Advance the shadow deframer by one received byte; queue a record when a
  // frame closes.
  function automatic void deframe_byte(input logic [7:0] rx);
    logic [31:0]  window;
    logic [7:0]   last_pos;
    int unsigned  slot;
    gyro_record_t rec;
    if (!collecting) begin
      window = {hunt_hist, rx};
      // cleared history never counts, so three real bytes must be held
      if (frame_pos >= HIST_FULL && window == sync_word) begin
        collecting = 1'b1;
        frame_pos  = HDR_BYTES;
        hunt_hist  = '0;
      end else begin
        hunt_hist = window[HIST_W-1:0];
        if (frame_pos < HIST_FULL)
          frame_pos = frame_pos + 8'd1;
      end
    end else begin
      if (frame_pos >= HDR_BYTES && frame_pos < MIN_FRAME) begin
        slot = (frame_pos - HDR_BYTES) >> 2;
        word_buf[slot][frame_pos[1:0]*8 +: 8] = rx;
      end
      // short lengths act as the minimum frame
      last_pos = (frame_len < MIN_FRAME) ? MIN_FRAME - 8'd1 : frame_len - 8'd1;
      // a length cut below the current offset leaves only the 255 stop
      if (frame_pos == last_pos || frame_pos == MAX_OFF) begin
        rec.frame_counter = word_buf[0];
        rec.rate_x        = word_buf[1];
        rec.rate_y        = word_buf[2];
        rec.rate_z        = word_buf[3];
        pending_records.push_back(rec);
        collecting = 1'b0;
        frame_pos  = '0;
        hunt_hist  = '0;
      end else begin
        frame_pos = frame_pos + 8'd1;
      end
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // Check the record first, then predict from the input transfer of the same
  // edge; a record can never leave on the edge that its last byte arrives.
  always @(posedge clk) begin
    gyro_record_t got;
    gyro_record_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_records.size() == 0) begin
          $error("record with no expectation waiting: %h", out_tdata);
          error_count++;
        end else begin
          want = pending_records.pop_front();
          records_checked++;
          compare_field("frame_counter", want.frame_counter, got.frame_counter);
          compare_field("rate_x", want.rate_x, got.rate_x);
          compare_field("rate_y", want.rate_y, got.rate_y);
          compare_field("rate_z", want.rate_z, got.rate_z);
        end
      end
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        bytes_moved++;
      end
      if (cfg_we) begin
        if (cfg_addr == REG_SYNC_PATTERN)
          sync_word = cfg_wdata;
        else
          frame_len = cfg_wdata[7:0];
        reg_writes++;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Offer one byte, idling first at random, and hold it until the transfer.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_sync();
    for (int i = 0; i < 4; i++)
      send_byte(sync_word[31-8*i -: 8]);
  endtask

  task automatic send_payload(input int unsigned count);
    repeat (count) send_byte(8'($urandom));
  endtask

  // Stop sending, wait for every record, then let the block settle.
  task automatic drain_records();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Waiting with cfg_we low after each write keeps it from being lowered and raised
  // in one step.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pressure(input int unsigned idle_pct, input int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // Reset pattern is all zeros: three zero bytes only fill history, the
  // fourth matches. Payload bytes reach both ends of the byte range.
  task automatic test_zero_pattern_after_reset();
    logic [127:0] body;
    body = 128'h10204080_08040201_00000000_FFFFFFFF;
    repeat (4) send_byte(8'h00);
    for (int i = 0; i < 16; i++)
      send_byte(body[i*8 +: 8]);
    drain_records();
  endtask

  // A near-miss header, then a real one with a length below the minimum.
  task automatic test_broken_sync_short_length();
    write_reg(REG_SYNC_PATTERN, 32'hA55AC33C);
    write_reg(REG_FRAME_LENGTH, 32'd0);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hC3);
    send_byte(8'h00);
    send_sync();
    send_payload(16);
    drain_records();
  endtask

  // Longest frame, payload full of sync bytes that must not restart it.
  task automatic test_sync_in_payload_max_length();
    write_reg(REG_SYNC_PATTERN, 32'hFFFFFFFF);
    write_reg(REG_FRAME_LENGTH, 32'd255);
    send_sync();
    for (int i = 0; i < 251; i++)
      send_byte((i % 3 == 0) ? 8'($urandom) : 8'hFF);
    drain_records();
  endtask

  // Length changed while collecting: cut below the offset, then extended.
  task automatic test_length_change_mid_frame();
    write_reg(REG_SYNC_PATTERN, 32'h12345678);
    write_reg(REG_FRAME_LENGTH, 32'd40);
    send_sync();
    send_payload(26);
    drain_records();
    write_reg(REG_FRAME_LENGTH, 32'd20);
    send_payload(226);            // offsets 30 up to the 255 stop
    drain_records();
    send_sync();
    send_payload(10);
    drain_records();
    write_reg(REG_FRAME_LENGTH, 32'd30);
    send_payload(16);
    drain_records();
  endtask

  // Mostly whole frames with random content, some broken headers and noise.
  task automatic run_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned eff_len;
    start = bytes_moved;
    while (bytes_moved - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        eff_len = (frame_len < MIN_FRAME) ? MIN_FRAME : frame_len;
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
        send_sync();
        send_payload(eff_len - HDR_BYTES);
      end else if (pick < 85) begin
        for (int i = 0; i < $urandom_range(1, 3); i++)
          send_byte(sync_word[31-8*i -: 8]);
        send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    logic [31:0] phase_sync [NUM_PHASES];
    logic [31:0] phase_len [NUM_PHASES];
    phase_sync = '{32'h00000000, $urandom, 32'hFFFFFFFF, $urandom,
                   32'h00FF00FF, $urandom, $urandom, $urandom};
    phase_len  = '{32'd20, 32'd0, 32'd19, 32'd27, 32'd255,
                   32'($urandom_range(20, 48)), 32'd21, 32'd36};
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_records();
      write_reg(REG_SYNC_PATTERN, phase_sync[p]);
      write_reg(REG_FRAME_LENGTH, phase_len[p]);
      case (p % 4)
        0: set_pressure(0, 0);
        1: set_pressure(55, 0);
        2: set_pressure(0, 55);
        default: set_pressure(29, 29);
      endcase
      run_traffic(PHASE_BYTES);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_pressure(29, 29);
    test_zero_pattern_after_reset();
    test_broken_sync_short_length();
    test_sync_in_payload_max_length();
    test_length_change_mid_frame();
    test_random_phases();
    drain_records();
    $display("Covered %0d byte transfers and %0d gyro records across %0d register writes,",
             bytes_moved, records_checked, reg_writes);
    $display("with idle and stall mixes, short, cut and maximum frame lengths.");
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $error("run did not complete in time");
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/swffe_pkg.sv
src/swffe_word_capture.sv
src/sync_word_frame_field_extractor.sv
src/swffe_checker.sv
tb/tb_sync_word_frame_field_extractor.sv
